// ----- hdl/sidta_pkg.sv -----
package sidta_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int BCD_DIGITS    = 10;
   localparam int BCD_WIDTH     = 4 * BCD_DIGITS;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = DATA_WIDTH / BITS_PER_STEP;
   localparam int STEP_WIDTH    = $clog2(CONV_STEPS);
   localparam int CHAR_WIDTH    = 8;
   localparam int LEN_WIDTH     = 4;
   localparam int CAP_WIDTH     = 4;
   localparam int ADDR_WIDTH    = 3;
   localparam int CSR_WIDTH     = 32;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CAP_WIDTH-1:0]  CAP_RESET  = 4'd12;

   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic start;
      logic step;
      logic size;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

// ----- hdl/sidta_ctrl.sv -----
module sidta_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sidta_pkg::status_type status,
   output sidta_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SIZE = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.start = 1'b1;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (status.conv_last) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/sidta_dp.sv -----
module sidta_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sidta_pkg::cmd_type                   cmd,
   output sidta_pkg::status_type                status,
   input  logic signed [sidta_pkg::DATA_WIDTH-1:0] req_value,
   input  logic [sidta_pkg::CAP_WIDTH-1:0]      capacity,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sidta_pkg::CHAR_WIDTH-1:0]     rsp_char_code,
   output logic [sidta_pkg::LEN_WIDTH-1:0]      rsp_length,
   output logic                                 rsp_is_last,
   output logic                                 rsp_is_empty
);

   localparam int DW = sidta_pkg::DATA_WIDTH;
   localparam int BW = sidta_pkg::BCD_WIDTH;
   localparam int LW = sidta_pkg::LEN_WIDTH;

   logic [DW-1:0]                       mag_ff, mag_in;
   logic [BW-1:0]                       bcd_ff, bcd_in;
   logic [sidta_pkg::STEP_WIDTH-1:0]    cnt_ff;
   logic                                neg_ff;
   logic                                zero_ff;
   logic [LW-1:0]                       pos_ff;
   logic [LW-1:0]                       len_ff;
   logic                                sign_ff;
   logic                                valid_ff;
   logic [sidta_pkg::CHAR_WIDTH-1:0]    char_ff;
   logic [LW-1:0]                       length_ff;
   logic                                last_ff;
   logic                                empty_ff;

   logic [DW-1:0]                       start_mag;
   logic [LW-1:0]                       num_digits;
   logic [LW-1:0]                       limit;
   logic [LW-1:0]                       eff_limit;
   logic [LW-1:0]                       keep_digits;
   logic                                keep_sign;
   logic [LW-1:0]                       pos_dec;
   logic [3:0]                          digit;
   logic [sidta_pkg::CHAR_WIDTH-1:0]    next_char;
   logic                                next_last;

   assign start_mag = req_value[DW-1] ? (~req_value + 1'b1) : req_value;

   always_comb begin
      bcd_in = bcd_ff;
      mag_in = mag_ff;
      for (int s = 0; s < sidta_pkg::BITS_PER_STEP; s++) begin
         for (int d = 0; d < sidta_pkg::BCD_DIGITS; d++) begin
            if (bcd_in[4*d +: 4] >= 4'd5) begin
               bcd_in[4*d +: 4] = bcd_in[4*d +: 4] + 4'd3;
            end
         end
         {bcd_in, mag_in} = {bcd_in, mag_in} << 1;
      end
   end

   always_comb begin
      num_digits = LW'(1);
      for (int d = 0; d < sidta_pkg::BCD_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] != 4'd0) begin
            num_digits = LW'(d + 1);
         end
      end
      limit = (capacity == '0) ? '0 : capacity - 1'b1;
      if (zero_ff) begin
         eff_limit = (capacity == '0) ? '0 : LW'(1);
      end else begin
         eff_limit = limit;
      end
      keep_digits = (num_digits < eff_limit) ? num_digits : eff_limit;
      keep_sign   = neg_ff && (keep_digits < eff_limit);
   end

   assign pos_dec = pos_ff - 1'b1;
   assign digit   = bcd_ff[{pos_dec, 2'b00} +: 4];

   always_comb begin
      if (len_ff == '0) begin
         next_char = '0;
         next_last = 1'b1;
      end else if (sign_ff) begin
         next_char = sidta_pkg::CHAR_MINUS;
         next_last = (pos_ff == '0);
      end else begin
         next_char = sidta_pkg::CHAR_ZERO + {4'b0000, digit};
         next_last = (pos_ff == LW'(1));
      end
   end

   assign status.conv_last = (cnt_ff == sidta_pkg::STEP_WIDTH'(sidta_pkg::CONV_STEPS - 1));
   assign status.emit_last = next_last;
   assign status.out_free  = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mag_ff  <= start_mag;
         bcd_ff  <= '0;
         cnt_ff  <= '0;
         neg_ff  <= req_value[DW-1];
         zero_ff <= (req_value == '0);
      end else if (cmd.step) begin
         mag_ff <= mag_in;
         bcd_ff <= bcd_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.size) begin
         pos_ff  <= keep_digits;
         sign_ff <= keep_sign;
         len_ff  <= keep_digits + LW'(keep_sign);
      end else if (cmd.emit) begin
         if (sign_ff) begin
            sign_ff <= 1'b0;
         end else if (pos_ff != '0) begin
            pos_ff <= pos_dec;
         end
      end
      if (cmd.emit) begin
         char_ff   <= next_char;
         length_ff <= len_ff;
         last_ff   <= next_last;
         empty_ff  <= (len_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_length    = length_ff;
   assign rsp_is_last   = last_ff;
   assign rsp_is_empty  = empty_ff;

endmodule

// ----- hdl/signed_int_to_decimal_ascii.sv -----
// Signed 32-bit integer to decimal ASCII text, one character per output beat.
// The request channel (req_valid, req_stall, req_value) takes one value per
// beat. The response channel emits the characters most significant first;
// every beat carries the total length, and the final beat has rsp_is_last set.
// When nothing fits, a single beat with rsp_is_empty and rsp_is_last is sent.
// The capacity register at address 0 of the APB port counts a terminator
// slot, so a nonzero input value gets at most capacity minus one characters.
// A value is converted to BCD four bits per cycle, then the SIZE state sizes
// the string, and the beats follow one per cycle while the receiver does not
// stall. The next request is taken as soon as the last beat sits in the
// output register. While the receiver stalls, the output beat holds, and
// while beats remain to be emitted the block waits with req_stall high.
// Reset clears both channels and sets capacity to 12; no request is
// accepted during reset.
module signed_int_to_decimal_ascii (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [sidta_pkg::DATA_WIDTH-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [sidta_pkg::CHAR_WIDTH-1:0]        rsp_char_code,
   output logic [sidta_pkg::LEN_WIDTH-1:0]         rsp_length,
   output logic                                    rsp_is_last,
   output logic                                    rsp_is_empty,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [sidta_pkg::ADDR_WIDTH-1:0]        paddr,
   input  logic [sidta_pkg::CSR_WIDTH-1:0]         pwdata,
   output logic [sidta_pkg::CSR_WIDTH-1:0]         prdata,
   output logic                                    pready
);

   sidta_pkg::cmd_type    cmd;
   sidta_pkg::status_type status;

   logic [sidta_pkg::CAP_WIDTH-1:0] capacity_ff;
   logic                            reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == sidta_pkg::REG_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= sidta_pkg::CAP_RESET;
      end else if (psel && penable && pwrite && reg_sel) begin
         capacity_ff <= pwdata[sidta_pkg::CAP_WIDTH-1:0];
      end
   end

   assign prdata = reg_sel ? sidta_pkg::CSR_WIDTH'(capacity_ff) : '0;

   sidta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sidta_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_value     (req_value),
      .capacity      (capacity_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_length    (rsp_length),
      .rsp_is_last   (rsp_is_last),
      .rsp_is_empty  (rsp_is_empty)
   );

endmodule

// ----- hdl/sidta_checker.sv -----
module sidta_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [sidta_pkg::CHAR_WIDTH-1:0]     rsp_char_code,
   input logic [sidta_pkg::LEN_WIDTH-1:0]      rsp_length,
   input logic                                 rsp_is_last,
   input logic                                 rsp_is_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_code)
         && $stable(rsp_length) && $stable(rsp_is_last) && $stable(rsp_is_empty))
      else $error("Stalled response beat changed.");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_is_last && rsp_length == '0
         && rsp_char_code == '0)
      else $error("Empty beat is malformed.");

   a_char_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_empty |-> rsp_length != '0
         && (rsp_char_code == sidta_pkg::CHAR_MINUS
             || (rsp_char_code >= sidta_pkg::CHAR_ZERO
                 && rsp_char_code <= sidta_pkg::CHAR_ZERO + 8'd9)))
      else $error("Character beat has a bad code or zero length.");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response valid right after reset.");

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_sidta_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_char_code (rsp_char_code),
   .rsp_length    (rsp_length),
   .rsp_is_last   (rsp_is_last),
   .rsp_is_empty  (rsp_is_empty)
);

// ----- tb/signed_int_to_decimal_ascii_test.sv -----
module signed_int_to_decimal_ascii_test;

   localparam int DATA_WIDTH = sidta_pkg::DATA_WIDTH;
   localparam int CHAR_WIDTH = sidta_pkg::CHAR_WIDTH;
   localparam int LEN_WIDTH  = sidta_pkg::LEN_WIDTH;
   localparam int CAP_WIDTH  = sidta_pkg::CAP_WIDTH;
   localparam int ADDR_WIDTH = sidta_pkg::ADDR_WIDTH;
   localparam int CSR_WIDTH  = sidta_pkg::CSR_WIDTH;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = sidta_pkg::CHAR_ZERO;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = sidta_pkg::CHAR_MINUS;
   localparam logic [CAP_WIDTH-1:0]  CAP_RESET  = sidta_pkg::CAP_RESET;
   localparam logic                  REG_CAPACITY = sidta_pkg::REG_CAPACITY;

   localparam int RADIX = 10;
   localparam int MAX_CHARS = 11;
   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 30;
   localparam logic [ADDR_WIDTH-1:0] CAPACITY_ADDR = ADDR_WIDTH'(4 * REG_CAPACITY);
   localparam logic [ADDR_WIDTH-1:0] UNMAPPED_ADDR = ADDR_WIDTH'(4);

   typedef struct {
      logic [CHAR_WIDTH-1:0] char_code;
      logic [LEN_WIDTH-1:0]  length;
      logic                  is_last;
      logic                  is_empty;
   } text_beat_type;

   class text_scoreboard;
      logic [CAP_WIDTH-1:0] capacity;
      text_beat_type        pending[$];
      int                   errors;
      int                   values_seen;
      int                   beats_checked;
      int                   empty_beats;

      function new();
         capacity = CAP_RESET;
         errors = 0;
         values_seen = 0;
         beats_checked = 0;
         empty_beats = 0;
      endfunction

      function void write_register(logic [ADDR_WIDTH-1:0] addr, logic [CSR_WIDTH-1:0] data);
         if (addr == CAPACITY_ADDR) begin
            capacity = data[CAP_WIDTH-1:0];
         end
      endfunction

      // Digits are produced least significant first and emitted in reverse.
      function void note_value(logic signed [DATA_WIDTH-1:0] value);
         logic [DATA_WIDTH-1:0] mag;
         logic                  neg;
         logic [CHAR_WIDTH-1:0] rev [MAX_CHARS + 1];
         int                    count;
         int                    limit;
         text_beat_type         beat;
         values_seen++;
         neg = value[DATA_WIDTH-1];
         mag = neg ? -value : value;
         count = 0;
         if (mag == 0) begin
            if (capacity > 0) begin
               rev[count] = CHAR_ZERO;
               count++;
            end
         end else begin
            limit = (capacity > 0) ? int'(capacity) - 1 : 0;
            while (mag > 0 && count < limit && count < MAX_CHARS) begin
               rev[count] = CHAR_ZERO + CHAR_WIDTH'(mag % RADIX);
               count++;
               mag = mag / RADIX;
            end
            if (neg && count < limit && count < MAX_CHARS) begin
               rev[count] = CHAR_MINUS;
               count++;
            end
         end
         if (count == 0) begin
            beat.char_code = '0;
            beat.length = '0;
            beat.is_last = 1'b1;
            beat.is_empty = 1'b1;
            pending.push_back(beat);
         end else begin
            for (int k = 0; k < count; k++) begin
               beat.char_code = rev[count - 1 - k];
               beat.length = LEN_WIDTH'(count);
               beat.is_last = (k == count - 1);
               beat.is_empty = 1'b0;
               pending.push_back(beat);
            end
         end
      endfunction

      function void check_beat(logic [CHAR_WIDTH-1:0] char_code, logic [LEN_WIDTH-1:0] length,
                               logic is_last, logic is_empty);
         text_beat_type want;
         beats_checked++;
         if (is_empty) begin
            empty_beats++;
         end
         if (pending.size() == 0) begin
            $error("Unexpected result beat: char_code %h length %0d", char_code, length);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (char_code !== want.char_code) begin
            $error("char_code: expected %h, got %h", want.char_code, char_code);
            errors++;
         end
         if (length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, length);
            errors++;
         end
         if (is_last !== want.is_last) begin
            $error("is_last: expected %b, got %b", want.is_last, is_last);
            errors++;
         end
         if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %b, got %b", want.is_empty, is_empty);
            errors++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [DATA_WIDTH-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [CHAR_WIDTH-1:0]        rsp_char_code;
   logic [LEN_WIDTH-1:0]         rsp_length;
   logic                         rsp_is_last;
   logic                         rsp_is_empty;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0]        paddr = '0;
   logic [CSR_WIDTH-1:0]         pwdata = '0;
   logic [CSR_WIDTH-1:0]         prdata;
   logic                         pready;

   text_scoreboard sb = new();
   bit             calm = 1'b0;
   bit             hold_req = 1'b0;
   int             idle_cycles = 0;
   int             settings_used = 1;

   signed_int_to_decimal_ascii u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_length    (rsp_length),
      .rsp_is_last   (rsp_is_last),
      .rsp_is_empty  (rsp_is_empty),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_beat(rsp_char_code, rsp_length, rsp_is_last, rsp_is_empty);
         end
         if (req_valid && !req_stall) begin
            sb.note_value(req_value);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || (psel && penable)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // The receiver stalls at random, never while calm is set, and holds off
   // for a long stretch when asked so the block backs up into its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end
         if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 20);
         end
      end
   end

   task automatic send_value(input logic signed [DATA_WIDTH-1:0] value);
      if (!calm) begin
         while ($urandom_range(99) < 20) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic apb_access(input logic write_en, input logic [ADDR_WIDTH-1:0] addr,
                             input logic [CSR_WIDTH-1:0] data, output logic [CSR_WIDTH-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write_en;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic write_csr(input logic [ADDR_WIDTH-1:0] addr, input logic [CSR_WIDTH-1:0] data);
      logic [CSR_WIDTH-1:0] unused;
      apb_access(1'b1, addr, data, unused);
      sb.write_register(addr, data);
   endtask

   task automatic check_capacity();
      logic [CSR_WIDTH-1:0] rdata;
      apb_access(1'b0, CAPACITY_ADDR, '0, rdata);
      if (rdata[CAP_WIDTH-1:0] !== sb.capacity) begin
         $error("capacity: expected %0d, got %0d", sb.capacity, rdata[CAP_WIDTH-1:0]);
         sb.errors++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      logic signed [DATA_WIDTH-1:0] edges [6];
      logic [DATA_WIDTH-1:0]        mag;
      int unsigned                  lo;
      int unsigned                  hi;
      int unsigned                  digits;
      edges = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001};
      unique case ($urandom_range(9))
         0: begin
            return edges[$urandom_range(5)];
         end
         1, 2, 3, 4, 5: begin
            digits = $urandom_range(1, 10);
            lo = 1;
            for (int i = 1; i < digits; i++) begin
               lo = lo * RADIX;
            end
            hi = (digits == 10) ? 32'h7FFFFFFF : lo * RADIX - 1;
            if (digits == 1) begin
               lo = 0;
            end
            mag = $urandom_range(hi, lo);
            return ($urandom_range(1) != 0) ? -mag : mag;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic run_setting(input int cap, input int count);
      drain();
      write_csr(CAPACITY_ADDR, {$urandom} & ~CSR_WIDTH'(4'hF) | CSR_WIDTH'(cap));
      check_capacity();
      settings_used++;
      for (int i = 0; i < count; i++) begin
         send_value(pick_value());
      end
   endtask

   initial begin
      logic signed [DATA_WIDTH-1:0] directed [$];
      directed = '{32'sd0, 32'sd7, -32'sd7, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
                   32'sd12345, -32'sd12345, 32'sd1000000000, -32'sd999999999,
                   32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001, -32'sd1};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_capacity();

      foreach (directed[i]) begin
         send_value(directed[i]);
      end

      run_setting(0, 20);
      run_setting(1, 25);
      run_setting(2, 25);
      run_setting(3, 25);
      calm = 1'b1;
      run_setting(15, 35);
      calm = 1'b0;
      drain();
      write_csr(UNMAPPED_ADDR, 32'h0000_0005);
      check_capacity();
      run_setting(7, 30);
      run_setting(11, 5);
      hold_req = 1'b1;
      for (int i = 0; i < 35; i++) begin
         send_value(pick_value());
      end
      run_setting(13, 25);
      run_setting(12, 40);
      repeat (4) begin
         run_setting($urandom_range(15), 25);
      end
      drain();

      $display("Converted %0d values into %0d beats, %0d of them empty,",
               sb.values_seen, sb.beats_checked, sb.empty_beats);
      $display("under %0d capacity settings.", settings_used);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
